// ===== hdl/bcd_calendar_date_advance_assert.svh =====
// Assertion helpers for the calendar date block.
// They expect clk_i and rst_ni in the scope of use.
`ifndef BCD_CALENDAR_DATE_ADVANCE_ASSERT_SVH
`define BCD_CALENDAR_DATE_ADVANCE_ASSERT_SVH

// Same-cycle implication
`define BCDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BCDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bcda_pkg.sv =====
package bcda_pkg;

  // Field widths of the channel words
  localparam int unsigned DayW   = 6;
  localparam int unsigned MonthW = 5;
  localparam int unsigned YearW  = 16;

  // Command codes
  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [DayW-1:0]   load_day_bcd;
    logic [MonthW-1:0] load_month_bcd;
    logic [YearW-1:0]  load_year_bcd;
  } in_word_t;

  typedef struct packed {
    logic [DayW-1:0]   day_bcd;
    logic [MonthW-1:0] month_bcd;
    logic [YearW-1:0]  year_bcd;
    logic              year_wrapped;
    logic              is_palindrome;
  } out_word_t;

  // Days in a month, non-leap; zero for a month outside 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] mon);
    logic [DayW-1:0] len;
    len = '0;
    unique case (mon) inside
      5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: len = 6'd31;
      5'd4, 5'd6, 5'd9, 5'd11:                    len = 6'd30;
      5'd2:                                       len = 6'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/bcda_chan_if.sv =====
// Valid/ready channel carrying one word per handshake
interface bcda_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== hdl/bcd_calendar_date_advance.sv =====
// Packed-BCD calendar date counter. Each input word either loads a date
// (cmd = load) or steps the stored date forward by one day (cmd = advance),
// handling month lengths, Gregorian leap Februaries and month/year carries.
// Every word yields one output word with the new date, a year-wrap flag and
// a DDMMYYYY palindrome flag. One word per cycle is sustained unless the
// receiver stalls. A word passes an input register, one pass of the
// day/month/year carry logic and the result register; a stalled full result
// register holds a full input register. YEAR_DIGITS (4..8) sets the stored
// year width; the output year carries its low four digits. Reset date is 01-01-0001.
module bcd_calendar_date_advance #(
  parameter int unsigned YEAR_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcda_chan_if.sink   in_i,
  bcda_chan_if.source out_o
);
  import bcda_pkg::*;

  localparam int unsigned StYearW = 4 * YEAR_DIGITS;
  localparam int unsigned NumDig  = 4 + YEAR_DIGITS;

  // Pipeline registers
  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t out_q;
  logic      out_valid_q;

  // Date state
  logic [DayW-1:0]    day_q, day_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic [StYearW-1:0] year_q, year_d;
  logic               wrapped;
  logic               palin;

  logic advance;
  logic step;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_q;

  // Next date
  always_comb begin
    logic [2:0]         dhi;
    logic [3:0]         dlo;
    logic [1:0]         mhi;
    logic [3:0]         mlo;
    logic [DayW-1:0]    day_v;
    logic [MonthW-1:0]  mon_cur;
    logic [MonthW-1:0]  mon_v;
    logic [DayW-1:0]    len;
    logic [7:0]         low_v;
    logic [7:0]         low_rem;
    logic [7:0]         hi_v;
    logic               ge100;
    logic               div100;
    logic               leap;
    logic               carry;
    logic [3:0]         dig;
    logic [StYearW-1:0] yinc;

    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    wrapped = 1'b0;

    // Leap test on raw nibble weights; only the low four digits matter
    low_v   = 8'(year_q[7:4]) * 8'd10 + 8'(year_q[3:0]);
    ge100   = (low_v >= 8'd100);
    low_rem = ge100 ? (low_v - 8'd100) : low_v;
    div100  = (low_rem == 8'd0);
    hi_v    = 8'(year_q[15:12]) * 8'd10 + 8'(year_q[11:8]) + 8'(ge100);
    leap    = ((low_v[1:0] == 2'd0) && !div100) || (div100 && (hi_v[1:0] == 2'd0));

    mon_cur = 5'(month_q[4]) * 5'd10 + 5'(month_q[3:0]);
    len     = month_days(mon_cur);
    if ((mon_cur == 5'd2) && leap) begin
      len = 6'd29;
    end

    // Day increment
    dhi = 3'(day_q[5:4]);
    dlo = day_q[3:0];
    if (dlo >= 4'd9) begin
      dlo = 4'd0;
      dhi = dhi + 3'd1;
    end else begin
      dlo = dlo + 4'd1;
    end
    day_v = 6'(dhi) * 6'd10 + 6'(dlo);

    // Month increment
    mhi = 2'(month_q[4]);
    mlo = month_q[3:0];
    if (mlo >= 4'd9) begin
      mlo = 4'd0;
      mhi = mhi + 2'd1;
    end else begin
      mlo = mlo + 4'd1;
    end
    mon_v = 5'(mhi) * 5'd10 + 5'(mlo);

    // Year increment, digit by digit
    carry = 1'b1;
    yinc  = year_q;
    for (int k = 0; k < int'(YEAR_DIGITS); k++) begin
      dig = year_q[4*k +: 4];
      if (carry) begin
        if (dig >= 4'd9) begin
          yinc[4*k +: 4] = 4'd0;
        end else begin
          yinc[4*k +: 4] = dig + 4'd1;
          carry          = 1'b0;
        end
      end
    end

    if (in_q.cmd == CmdLoad) begin
      day_d   = in_q.load_day_bcd;
      month_d = in_q.load_month_bcd;
      year_d  = StYearW'(in_q.load_year_bcd);
    end else if (day_v > len) begin
      day_d = 6'h01;
      if (mon_v > 5'd12) begin
        month_d = 5'h01;
        year_d  = yinc;
        wrapped = carry;
      end else begin
        month_d = {mhi[0], mlo};
      end
    end else begin
      day_d = {dhi[1:0], dlo};
    end
  end

  // Palindrome over DDMMYYYY of the new date
  always_comb begin
    logic [3:0] dg [NumDig];
    dg[0] = {2'b00, day_d[5:4]};
    dg[1] = day_d[3:0];
    dg[2] = {3'b000, month_d[4]};
    dg[3] = month_d[3:0];
    for (int i = 0; i < int'(YEAR_DIGITS); i++) begin
      dg[4 + i] = year_d[4*(int'(YEAR_DIGITS) - 1 - i) +: 4];
    end
    palin = 1'b1;
    for (int i = 0; i < int'(NumDig / 2); i++) begin
      if (dg[i] != dg[int'(NumDig) - 1 - i]) begin
        palin = 1'b0;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      day_q       <= 6'h01;
      month_q     <= 5'h01;
      year_q      <= StYearW'(1);
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        day_q   <= day_d;
        month_q <= month_d;
        year_q  <= year_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.word;
    end
    if (step) begin
      out_q.day_bcd       <= day_d;
      out_q.month_bcd     <= month_d;
      out_q.year_bcd      <= year_d[YearW-1:0];
      out_q.year_wrapped  <= wrapped;
      out_q.is_palindrome <= palin;
    end
  end

`include "bcd_calendar_date_advance_assert.svh"

  // A wrap always lands on 01-01 with a zero year
  `BCDA_ASSERT_NOW(a_wrap_date, out_valid_q && out_q.year_wrapped, (out_q.day_bcd == 6'h01) && (out_q.month_bcd == 5'h01) && (out_q.year_bcd == '0), "year wrap without 01-01-0000")
  // A load never reports a wrap
  `BCDA_ASSERT_NEXT(a_load_nowrap, step && (in_q.cmd == CmdLoad), !out_q.year_wrapped, "year wrap on load")
  // Stalled pipeline leaves the date alone
  `BCDA_ASSERT_NEXT(a_stall_hold, in_valid_q && out_valid_q && !out_o.ready, $stable(day_q) && $stable(month_q) && $stable(year_q), "date changed while stalled")

endmodule

// ===== dv/bcda_date_checker.sv =====
// Watches both channels of the date counter, keeps its own copy of the
// stored date, predicts one result word per accepted input word and checks
// every result word against the oldest prediction.
module bcda_date_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  bcda_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  bcda_pkg::out_word_t out_word_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bcda_pkg::*;

  // Predicted calendar state
  logic [DayW-1:0]   date_day;
  logic [MonthW-1:0] date_month;
  logic [YearW-1:0]  date_year;

  out_word_t   expected_dates[$];
  out_word_t   want;
  int unsigned results_seen;

  // Month length with leap February; zero outside 1..12
  function automatic int month_length(input int mon, input bit leap);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("%0t ns: result %0d %s: got %0h, want %0h",
             $time, results_seen, what, got, exp_val);
    errors_o++;
  endtask

  // Apply one input word to the predicted date and build its result word
  task automatic apply_date_word(input in_word_t w, output out_word_t res);
    int dhi, dlo, mhi, mlo, yv;
    bit leap, carry;
    carry = 1'b0;
    if (w.cmd == CmdLoad) begin
      date_day   = w.load_day_bcd;
      date_month = w.load_month_bcd;
      date_year  = w.load_year_bcd;
    end else begin
      dhi = int'(date_day[5:4]);
      dlo = int'(date_day[3:0]);
      mhi = int'(date_month[4]);
      mlo = int'(date_month[3:0]);
      // units of the day count, any nibble of 9 or above carries
      if (dlo >= 9) begin
        dlo = 0;
        dhi++;
      end else begin
        dlo++;
      end
      // leap test weighs each nibble by its raw value
      yv = date_year[15:12] * 1000 + date_year[11:8] * 100
         + date_year[7:4] * 10 + date_year[3:0];
      leap = ((yv % 4 == 0) && (yv % 100 != 0)) || (yv % 400 == 0);
      if (dhi * 10 + dlo > month_length(mhi * 10 + mlo, leap)) begin
        dhi = 0;
        dlo = 1;
        if (mlo >= 9) begin
          mlo = 0;
          mhi++;
        end else begin
          mlo++;
        end
        // month past 12: back to January, ripple a BCD increment into the year
        if (mhi * 10 + mlo > 12) begin
          mhi = 0;
          mlo = 1;
          carry = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (carry) begin
              if (date_year[4*k +: 4] >= 4'd9) begin
                date_year[4*k +: 4] = 4'd0;
              end else begin
                date_year[4*k +: 4] = date_year[4*k +: 4] + 4'd1;
                carry = 1'b0;
              end
            end
          end
        end
      end
      date_day   = DayW'(((dhi & 3) << 4) | (dlo & 15));
      date_month = MonthW'(((mhi & 1) << 4) | (mlo & 15));
    end
    res.day_bcd      = date_day;
    res.month_bcd    = date_month;
    res.year_bcd     = date_year;
    res.year_wrapped = carry;
    // DDMMYYYY mirrored: D1=Y4, D0=Y3, M1=Y2, M0=Y1
    res.is_palindrome = (4'(date_day[5:4]) == date_year[3:0]) &&
                        (date_day[3:0] == date_year[7:4]) &&
                        (4'(date_month[4]) == date_year[11:8]) &&
                        (date_month[3:0] == date_year[15:12]);
  endtask

  // Results are checked before the same-edge input is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_day   = 6'h01;
      date_month = 5'h01;
      date_year  = 16'h0001;
      expected_dates.delete();
      results_seen = 0;
      errors_o     = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_dates.size() == 0) begin
          report_mismatch("arrived with nothing pending", 32'(out_word_i), 0);
        end else begin
          want = expected_dates.pop_front();
          if (out_word_i.day_bcd !== want.day_bcd)
            report_mismatch("day", 32'(out_word_i.day_bcd), 32'(want.day_bcd));
          if (out_word_i.month_bcd !== want.month_bcd)
            report_mismatch("month", 32'(out_word_i.month_bcd),
                            32'(want.month_bcd));
          if (out_word_i.year_bcd !== want.year_bcd)
            report_mismatch("year", 32'(out_word_i.year_bcd),
                            32'(want.year_bcd));
          if (out_word_i.year_wrapped !== want.year_wrapped)
            report_mismatch("year wrap", 32'(out_word_i.year_wrapped),
                            32'(want.year_wrapped));
          if (out_word_i.is_palindrome !== want.is_palindrome)
            report_mismatch("palindrome", 32'(out_word_i.is_palindrome),
                            32'(want.is_palindrome));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_date_word(in_word_i, want);
        expected_dates.push_back(want);
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

// ===== dv/tb_bcd_calendar_date_advance.sv =====
module tb_bcd_calendar_date_advance;
  timeunit 1ns;
  timeprecision 1ps;
  import bcda_pkg::*;

  localparam int unsigned RandomWords = 1850;
  localparam int unsigned IdleLimit   = 2000;

  logic clk_i;
  logic rst_ni;

  bcda_chan_if #(.word_t(in_word_t))  date_in ();
  bcda_chan_if #(.word_t(out_word_t)) date_out ();

  int unsigned check_errors;
  int unsigned check_pending;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  ready_phase   = '0;

  bcd_calendar_date_advance i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (date_in),
    .out_o  (date_out)
  );

  bcda_date_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (date_in.valid),
    .in_ready_i  (date_in.ready),
    .in_word_i   (date_in.word),
    .out_valid_i (date_out.valid),
    .out_ready_i (date_out.ready),
    .out_word_i  (date_out.word),
    .errors_o    (check_errors),
    .pending_o   (check_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls: a 16-bit ready pattern, indexed by the low phase bits and redrawn when the phase counter wraps
  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase == '1) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= '1;
        1:       ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
        default: ready_pattern <= 16'($urandom) | 16'h0001;
      endcase
    end
    date_out.ready <= ready_pattern[ready_phase[3:0]];
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((date_in.valid && date_in.ready) || (date_out.valid && date_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("bcd_calendar_date_advance verification failed");
      $finish;
    end
  end

  function automatic in_word_t make_word(input logic cmd, input logic [DayW-1:0] day,
                                         input logic [MonthW-1:0] month,
                                         input logic [YearW-1:0] year);
    in_word_t w;
    w.cmd            = cmd;
    w.load_day_bcd   = day;
    w.load_month_bcd = month;
    w.load_year_bcd  = year;
    return w;
  endfunction

  // Any in-range field pattern, decimal or not
  function automatic in_word_t random_fields(input logic cmd);
    return make_word(cmd, DayW'($urandom_range(0, 49)), MonthW'($urandom_range(0, 18)),
                     YearW'($urandom_range(0, 39321)));
  endfunction

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Present one word, hold it until taken, then maybe open a gap
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    date_in.valid <= 1'b1;
    date_in.word  <= w;
    do @(posedge clk_i); while (!date_in.ready);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        date_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    date_in.valid <= 1'b0;
    @(posedge clk_i);
    while (check_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned run_len;
    int d, m;
    logic [YearW-1:0] y;
    bit paused;
    paused = 1'b0;
    rst_ni        <= 1'b0;
    date_in.valid <= 1'b0;
    date_in.word  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset date, wraps, leap rules, palindromes, odd digits
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h31, 5'h12, 16'h9999));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h28, 5'h02, 16'h2024));
    send_word(random_fields(CmdAdvance));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h28, 5'h02, 16'h1900));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h28, 5'h02, 16'h2000));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h30, 5'h04, 16'h2023));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h31, 5'h01, 16'h2010));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h29, 5'h11, 16'h1192));
    send_word(make_word(CmdLoad, 6'h00, 5'h00, 16'h0000));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h1C, 5'h0F, 16'h1A09));
    send_word(random_fields(CmdAdvance));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h31, 5'h12, 16'h00A9));
    send_word(random_fields(CmdAdvance));
    send_word(make_word(CmdLoad, 6'h05, 5'h0D, 16'h1999));
    send_word(random_fields(CmdAdvance));
    drain_results();

    // Random: mostly valid dates followed by day runs, some raw patterns
    words_sent = 0;
    while (words_sent < RandomWords) begin
      if (!paused && words_sent >= RandomWords / 2) begin
        drain_results();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          send_word(random_fields(CmdLoad));
          run_len = $urandom_range(1, 6);
        end
        2: begin
          send_word(random_fields($urandom_range(0, 1) ? CmdAdvance : CmdLoad));
          run_len = 0;
        end
        default: begin
          m = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
          d = $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(1, 31);
          case ($urandom_range(0, 7))
            0:       y = 16'h9999;
            1:       y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 8'h00};
            2:       y = {8'h99, to_bcd($urandom_range(90, 99))};
            default: y = {to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(0, 99))};
          endcase
          send_word(make_word(CmdLoad, DayW'(to_bcd(d)), MonthW'(to_bcd(m)), y));
          run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 40);
        end
      endcase
      repeat (run_len) send_word(random_fields(CmdAdvance));
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (check_errors == 0)
      $display("bcd_calendar_date_advance verification clean");
    else
      $display("bcd_calendar_date_advance verification failed");
    $finish;
  end

endmodule
